// ===== rtl/blrt_pkg.sv =====
package blrt_pkg;

    localparam int GRAD_W = 48;
    localparam int WORD_W = 32;

    localparam logic [1:0] REQ_LOAD_FEATURE = 2'd0;
    localparam logic [1:0] REQ_LOAD_TARGET  = 2'd1;
    localparam logic [1:0] REQ_TRAIN        = 2'd2;

    localparam logic [2:0] CFG_NUM_FEATURES  = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_COUNT  = 3'd1;
    localparam logic [2:0] CFG_LEARNING_RATE = 3'd2;
    localparam logic [2:0] CFG_TOLERANCE     = 3'd3;
    localparam logic [2:0] CFG_MAX_EPOCHS    = 3'd4;

    typedef struct packed {
        logic feat_we;
        logic tgt_we;
    } store_we_t;

endpackage

// ===== rtl/blrt_sample_store.sv =====
module blrt_sample_store #(
    parameter int FDEPTH = 4096,
    parameter int TDEPTH = 256,
    parameter int FAW    = 12,
    parameter int TAW    = 8
) (
    input  logic                      clk,
    input  blrt_pkg::store_we_t       we,
    input  logic [FAW-1:0]            wr_faddr,
    input  logic [TAW-1:0]            wr_taddr,
    input  logic [31:0]               wr_data,
    input  logic [FAW-1:0]            rd_faddr,
    input  logic [TAW-1:0]            rd_taddr,
    output logic signed [31:0]        feat_rdata,
    output logic signed [31:0]        tgt_rdata
);
    import blrt_pkg::*;

    logic [WORD_W-1:0] feat_mem [FDEPTH];
    logic [WORD_W-1:0] tgt_mem  [TDEPTH];

    always_ff @(posedge clk)
    begin
        if (we.feat_we)
        begin
            feat_mem[wr_faddr] <= wr_data;
        end
        feat_rdata <= $signed(feat_mem[rd_faddr]);
    end

    always_ff @(posedge clk)
    begin
        if (we.tgt_we)
        begin
            tgt_mem[wr_taddr] <= wr_data;
        end
        tgt_rdata <= $signed(tgt_mem[rd_taddr]);
    end

endmodule

// ===== rtl/batch_lms_regression_trainer.sv =====
// train: per epoch, a prediction pass and a gradient pass over the features for each
// sample, both through the single feature memory read port, then a weight update
// pass; at the end num_features results are emitted
// throughput: one load per cycle while idle; one train request at a time
// reset: asynchronous active low; weights zero, config to defaults, sample memories undefined
module batch_lms_regression_trainer #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_SAMPLES  = 256,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_index[7:0], feature_index[11:8], value[43:12], zero fill
    input  logic [47:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // param_index[3:0], param_value[35:4], converged[36], epochs_used[52:37], zero fill
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import blrt_pkg::*;

    localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int FCW = $clog2(MAX_FEATURES + 1);
    localparam int SCW = $clog2(MAX_SAMPLES + 1);
    localparam int FAW = (MAX_SAMPLES * MAX_FEATURES > 1) ?
                         $clog2(MAX_SAMPLES * MAX_FEATURES) : 1;
    localparam int SAT_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam logic signed [55:0] SAT_HI = (56'sd1 <<< (SAT_W - 1)) - 56'sd1;
    localparam logic signed [55:0] SAT_LO = -SAT_HI - 56'sd1;
    localparam logic signed [48:0] G_HI = (49'sd1 <<< (GRAD_W - 1)) - 49'sd1;
    localparam logic signed [48:0] G_LO = -G_HI - 49'sd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_PRED  = 4'd2;
    localparam logic [3:0] S_PWAIT = 4'd3;
    localparam logic [3:0] S_ERR   = 4'd4;
    localparam logic [3:0] S_GRAD  = 4'd5;
    localparam logic [3:0] S_GWAIT = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_UWAIT = 4'd8;
    localparam logic [3:0] S_CHECK = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    localparam logic [1:0] PH_PRED = 2'd0;
    localparam logic [1:0] PH_GRAD = 2'd1;
    localparam logic [1:0] PH_UPD  = 2'd2;

    function automatic logic signed [31:0] sat_val(input logic signed [55:0] v);
        logic signed [55:0] r;
        r = v;
        if (v > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO;
        end
        return r[31:0];
    endfunction

    // configuration
    logic [4:0]  nf_cfg_reg;
    logic [8:0]  ns_cfg_reg;
    logic [15:0] rate_reg;
    logic [30:0] tol_reg;
    logic [15:0] max_ep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_cfg_reg <= 5'd16;
            ns_cfg_reg <= 9'd256;
            rate_reg   <= 16'd655;
            tol_reg    <= 31'd66;
            max_ep_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_FEATURES:  nf_cfg_reg <= cfg_data[4:0];
                CFG_SAMPLE_COUNT:  ns_cfg_reg <= cfg_data[8:0];
                CFG_LEARNING_RATE: rate_reg   <= cfg_data[15:0];
                CFG_TOLERANCE:     tol_reg    <= cfg_data[30:0];
                CFG_MAX_EPOCHS:    max_ep_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    logic [FCW-1:0] nf_eff;
    logic [SCW-1:0] ns_eff;

    always_comb
    begin
        if (nf_cfg_reg == 5'd0)
        begin
            nf_eff = FCW'(1);
        end
        else if (32'(nf_cfg_reg) > 32'(MAX_FEATURES))
        begin
            nf_eff = FCW'(MAX_FEATURES);
        end
        else
        begin
            nf_eff = FCW'(nf_cfg_reg);
        end
        if (ns_cfg_reg == 9'd0)
        begin
            ns_eff = SCW'(1);
        end
        else if (32'(ns_cfg_reg) > 32'(MAX_SAMPLES))
        begin
            ns_eff = SCW'(MAX_SAMPLES);
        end
        else
        begin
            ns_eff = SCW'(ns_cfg_reg);
        end
    end

    // input fields
    logic [7:0]         in_si;
    logic [3:0]         in_fi;
    logic [31:0]        in_val;
    logic               in_xfer;

    assign in_si   = s_axis_tdata[7:0];
    assign in_fi   = s_axis_tdata[11:8];
    assign in_val  = s_axis_tdata[43:12];

    logic [3:0]         state_reg;
    logic [SCW-1:0]     s_cnt_reg;
    logic [FCW-1:0]     i_cnt_reg;
    logic [15:0]        ep_reg;
    logic               conv_reg;
    logic               all_small_reg;
    logic signed [55:0] pred_reg;
    logic signed [31:0] err_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic [1:0]         ph1_reg;
    logic [1:0]         ph2_reg;
    logic [FIW-1:0]     idx1_reg;
    logic [FIW-1:0]     idx2_reg;
    logic signed [63:0] prod_reg;
    logic signed [64:0] uprod_reg;
    logic signed [31:0] w_reg [MAX_FEATURES];
    logic signed [47:0] grad_reg [MAX_FEATURES];
    logic               out_valid_reg;
    logic [55:0]        out_data_reg;
    logic               out_last_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // sample memories
    store_we_t          st_we;
    logic [FAW-1:0]     wr_faddr;
    logic [FAW-1:0]     rd_faddr;
    logic signed [31:0] feat_rdata;
    logic signed [31:0] tgt_rdata;

    assign st_we.feat_we = in_xfer && (s_axis_tuser == REQ_LOAD_FEATURE)
                           && (32'(in_si) < 32'(MAX_SAMPLES))
                           && (32'(in_fi) < 32'(MAX_FEATURES));
    assign st_we.tgt_we  = in_xfer && (s_axis_tuser == REQ_LOAD_TARGET)
                           && (32'(in_si) < 32'(MAX_SAMPLES));
    assign wr_faddr = FAW'(in_si) * FAW'(MAX_FEATURES) + FAW'(in_fi);
    assign rd_faddr = FAW'(s_cnt_reg) * FAW'(MAX_FEATURES) + FAW'(i_cnt_reg);

    blrt_sample_store #(
        .FDEPTH (MAX_SAMPLES * MAX_FEATURES),
        .TDEPTH (MAX_SAMPLES),
        .FAW    (FAW),
        .TAW    (SW)
    ) u_store (
        .clk        (clk),
        .we         (st_we),
        .wr_faddr   (wr_faddr),
        .wr_taddr   (SW'(in_si)),
        .wr_data    (in_val),
        .rd_faddr   (rd_faddr),
        .rd_taddr   (s_cnt_reg[SW-1:0]),
        .feat_rdata (feat_rdata),
        .tgt_rdata  (tgt_rdata)
    );

    // datapath terms
    logic               last_i;
    logic               emit_load;
    logic signed [47:0] gp_term;
    logic signed [48:0] g_sum;
    logic signed [47:0] g_sat;
    logic signed [48:0] upd;
    logic signed [49:0] upd_mag;
    logic signed [31:0] pred_sat;

    assign last_i    = (i_cnt_reg == nf_eff - FCW'(1));
    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);
    assign gp_term   = prod_reg[63:16];
    assign g_sum     = 49'(grad_reg[idx2_reg]) + 49'(gp_term);
    assign g_sat     = (g_sum > G_HI) ? G_HI[47:0] : ((g_sum < G_LO) ? G_LO[47:0] : g_sum[47:0]);
    assign upd       = uprod_reg[64:16];
    assign upd_mag   = (upd < 0) ? -50'(upd) : 50'(upd);
    assign pred_sat  = sat_val(pred_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            s_cnt_reg     <= '0;
            i_cnt_reg     <= '0;
            ep_reg        <= '0;
            conv_reg      <= 1'b0;
            all_small_reg <= 1'b1;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_FEATURES; k++)
            begin
                w_reg[k] <= '0;
            end
        end
        else
        begin
            v1_reg <= 1'b0;
            v2_reg <= v1_reg;

            // multiply stage
            if (v1_reg)
            begin
                ph2_reg  <= ph1_reg;
                idx2_reg <= idx1_reg;
                case (ph1_reg)
                    PH_PRED: prod_reg <= 64'(w_reg[idx1_reg]) * 64'(feat_rdata);
                    PH_GRAD: prod_reg <= 64'(err_reg) * 64'(feat_rdata);
                    default: uprod_reg <= 65'(grad_reg[idx1_reg]) * $signed({49'd0, rate_reg});
                endcase
            end

            // accumulate stage
            if (v2_reg)
            begin
                case (ph2_reg)
                    PH_PRED: pred_reg <= pred_reg + 56'($signed(prod_reg[63:16]));
                    PH_GRAD: grad_reg[idx2_reg] <= g_sat;
                    default:
                    begin
                        w_reg[idx2_reg] <= sat_val(56'(w_reg[idx2_reg]) + 56'(upd));
                        if (upd_mag >= $signed({19'd0, tol_reg}))
                        begin
                            all_small_reg <= 1'b0;
                        end
                    end
                endcase
            end

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && (s_axis_tuser == REQ_TRAIN))
                    begin
                        ep_reg    <= '0;
                        conv_reg  <= 1'b0;
                        i_cnt_reg <= '0;
                        state_reg <= (max_ep_reg == 16'd0) ? S_EMIT : S_CLR;
                    end
                end
                S_CLR:
                begin
                    for (int k = 0; k < MAX_FEATURES; k++)
                    begin
                        grad_reg[k] <= '0;
                    end
                    all_small_reg <= 1'b1;
                    s_cnt_reg     <= '0;
                    i_cnt_reg     <= '0;
                    pred_reg      <= '0;
                    state_reg     <= S_PRED;
                end
                S_PRED, S_GRAD, S_UPD:
                begin
                    v1_reg   <= 1'b1;
                    idx1_reg <= i_cnt_reg[FIW-1:0];
                    ph1_reg  <= (state_reg == S_PRED) ? PH_PRED :
                                ((state_reg == S_GRAD) ? PH_GRAD : PH_UPD);
                    if (last_i)
                    begin
                        state_reg <= state_reg + 4'd1;
                    end
                    else
                    begin
                        i_cnt_reg <= i_cnt_reg + FCW'(1);
                    end
                end
                S_PWAIT:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg   <= sat_val(56'(tgt_rdata) - 56'(pred_sat));
                    i_cnt_reg <= '0;
                    state_reg <= S_GRAD;
                end
                S_GWAIT:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        i_cnt_reg <= '0;
                        if (s_cnt_reg == ns_eff - SCW'(1))
                        begin
                            state_reg <= S_UPD;
                        end
                        else
                        begin
                            s_cnt_reg <= s_cnt_reg + SCW'(1);
                            pred_reg  <= '0;
                            state_reg <= S_PRED;
                        end
                    end
                end
                S_UWAIT:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    ep_reg    <= ep_reg + 16'd1;
                    i_cnt_reg <= '0;
                    if (all_small_reg)
                    begin
                        conv_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else if (ep_reg + 16'd1 == max_ep_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_CLR;
                    end
                end
                S_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_data_reg <= {3'd0, ep_reg, conv_reg,
                                         w_reg[i_cnt_reg[FIW-1:0]], 4'(i_cnt_reg)};
                        out_last_reg <= last_i;
                        if (last_i)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_cnt_reg <= i_cnt_reg + FCW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_err_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR) |-> (!v1_reg && !v2_reg))
        else $error("error formed before prediction pipeline drained");

    a_conv_epochs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[36]) |-> (out_data_reg[52:37] != 16'd0))
        else $error("converged with no epoch run");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> !v2_reg)
        else $error("pipeline active while idle");

    a_emit_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && last_i) |=> (state_reg == S_IDLE && out_valid_reg && out_last_reg))
        else $error("last result not followed by idle");

endmodule
